@@ hdl/lsms_pkg.sv @@
// Shared types and opcode constants for the load/store memory stage.
`default_nettype none
package lsms_pkg;

   localparam int ALU_W = 32;

   localparam logic [5:0] OP_LB = 6'h20;
   localparam logic [5:0] OP_LH = 6'h21;
   localparam logic [5:0] OP_LW = 6'h23;
   localparam logic [5:0] OP_SB = 6'h28;
   localparam logic [5:0] OP_SH = 6'h29;
   localparam logic [5:0] OP_SW = 6'h2B;

   localparam logic [31:0] MASK_TOP_BYTE   = 32'hFF00_0000;
   localparam logic [31:0] MASK_LOW_THREE  = 32'h00FF_FFFF;
   localparam logic [31:0] MASK_UPPER_HALF = 32'hFFFF_0000;
   localparam logic [31:0] MASK_LOWER_HALF = 32'h0000_FFFF;

   typedef struct packed {
      logic [5:0]  opcode;
      logic [1:0]  byte_offset;
      logic [31:0] alu_result;
      logic [4:0]  dest_reg;
      logic [31:0] reg_value;
      logic        mem_read_flag;
      logic        move_ctrl;
   } req_type;

   typedef struct packed {
      logic [5:0]  opcode_out;
      logic        mem_read_out;
      logic        move_ctrl_out;
      logic [4:0]  dest_reg_out;
      logic [31:0] reg_value_out;
      logic [31:0] data_out;
   } rsp_type;

   // Outcome of one instruction: memory write and the new held result fields.
   typedef struct packed {
      logic        wr_en;
      logic [31:0] wr_data;
      logic [4:0]  dest_reg;
      logic [31:0] reg_value;
      logic [31:0] data;
   } lane_result_type;

endpackage
`default_nettype wire

@@ hdl/load_store_memory_stage.sv @@
// Load/store memory stage: top level with clearing pass, read stage and write-back.
//
// After reset the stage sweeps the word memory to zero, one word per cycle, and busy
// stays high until the sweep has covered every word. A transaction is accepted when
// start is high and busy is low; its result appears on rsp_data with rsp_strobe high
// for one cycle. With a power-of-two MEM_WORDS the index is the low address bits, the
// memory read is issued at the accepting edge together with the s1 registers, and the
// lane result is registered into rsp_data with the strobe: one transaction per cycle,
// with back-to-back accesses to the same word forwarded from the write port. With any
// other depth the index is reduced by a reciprocal multiply (product register, then
// remainder register) ahead of the memory read, busy is high for one cycle after each
// accept, and a new transaction can be taken while the last one is still in flight.
// Results cannot be held off; rsp_data keeps its last value between strobes.
`default_nettype none
module load_store_memory_stage
   import lsms_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(MEM_WORDS);

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] clr_cnt_ff;

   logic             ix_busy;
   logic             ix_valid;
   logic [IDX_W-1:0] ix_idx;
   req_type          ix_req;

   logic             s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   req_type          s1_req_ff;
   logic             fwd_ff;
   logic [31:0]      fwd_data_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic [31:0]      rd_data;
   logic [31:0]      word;
   lane_result_type  lane;
   rsp_type          rsp_ff;
   logic             strobe_ff;

   assign busy = (state_ff == ST_CLEAR) || ix_busy;

   lsms_index_unit #(
      .MEM_WORDS (MEM_WORDS),
      .IDX_W     (IDX_W)
   ) u_index (
      .clock     (clock),
      .reset     (reset),
      .load      (start && !busy),
      .req_in    (req_data),
      .busy      (ix_busy),
      .idx_valid (ix_valid),
      .idx       (ix_idx),
      .req_out   (ix_req)
   );

   lsms_word_ram #(
      .DEPTH  (MEM_WORDS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (ix_valid),
      .rd_addr    (ix_idx),
      .rd_data_ff (rd_data)
   );

   // A write in the same cycle as the read of that word is newer than the RAM output.
   assign word = fwd_ff ? fwd_data_ff : rd_data;

   lsms_lane_unit u_lane (
      .req    (s1_req_ff),
      .word   (word),
      .held   (rsp_ff),
      .result (lane)
   );

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && lane.wr_en;
         wr_addr = s1_idx_ff;
         wr_data = lane.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         strobe_ff   <= 1'b0;
         rsp_ff      <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == IDX_W'(MEM_WORDS - 1)) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               state_ff <= ST_RUN;
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase

         s1_valid_ff <= ix_valid;
         if (ix_valid) begin
            s1_idx_ff <= ix_idx;
            s1_req_ff <= ix_req;
         end
         fwd_ff      <= ix_valid && wr_en && (wr_addr == ix_idx);
         fwd_data_ff <= wr_data;

         strobe_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_ff.opcode_out    <= s1_req_ff.opcode;
            rsp_ff.mem_read_out  <= s1_req_ff.mem_read_flag;
            rsp_ff.move_ctrl_out <= s1_req_ff.move_ctrl;
            rsp_ff.dest_reg_out  <= lane.dest_reg;
            rsp_ff.reg_value_out <= lane.reg_value;
            rsp_ff.data_out      <= lane.data;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

@@ hdl/lsms_word_ram.sv @@
// Synchronous word memory with one write port and one registered read port.
`default_nettype none
module lsms_word_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]            rd_data_ff
);

   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/lsms_index_unit.sv @@
// Reduces the ALU result to a word index modulo the memory depth.
`default_nettype none
module lsms_index_unit
   import lsms_pkg::*;
#(
   parameter int MEM_WORDS = 1024,
   parameter int IDX_W     = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire req_type     req_in,
   output logic             busy,
   output logic             idx_valid,
   output logic [IDX_W-1:0] idx,
   output req_type          req_out
);

   localparam bit IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         // Power-of-two depth: the index is just the low address bits.
         assign busy      = 1'b0;
         assign idx_valid = load;
         assign idx       = req_in.alu_result[IDX_W-1:0];
         assign req_out   = req_in;
      end else begin : g_recip
         // With SHIFT = 32 + IDX_W and the reciprocal rounded up, (x * RECIP) >> SHIFT
         // is the exact quotient for every 32-bit x. RECIP lies between 2^32 and 2^33,
         // so only its low 32 bits need a multiplier; the top bit is a shifted add.
         localparam int SHIFT = ALU_W + IDX_W;
         localparam logic [ALU_W-1:0] RECIP_LOW =
            ALU_W'(((64'd1 << SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
         localparam logic [IDX_W-1:0] MOD_LOW = IDX_W'(MEM_WORDS);

         logic                 running_ff;
         logic                 done_ff;
         logic [2*ALU_W:0]     prod_ff;
         logic [IDX_W-1:0]     alu_low_ff;
         logic [IDX_W-1:0]     rem_ff;
         logic [2*ALU_W-1:0]   low_prod;
         logic [2*ALU_W:0]     quot;
         logic [2*IDX_W-1:0]   quot_mod;
         req_type              req_ff;

         assign low_prod = {{ALU_W{1'b0}}, req_in.alu_result} * {{ALU_W{1'b0}}, RECIP_LOW};
         assign quot     = prod_ff >> SHIFT;
         // The remainder is below 2^IDX_W, so the low bits of q * M are all it needs.
         assign quot_mod = {{IDX_W{1'b0}}, quot[IDX_W-1:0]} * {{IDX_W{1'b0}}, MOD_LOW};

         always_ff @(posedge clock) begin
            if (reset) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b0;
            end else begin
               done_ff <= 1'b0;
               if (load) begin
                  running_ff <= 1'b1;
                  prod_ff    <= {1'b0, req_in.alu_result, {ALU_W{1'b0}}} + {1'b0, low_prod};
                  alu_low_ff <= req_in.alu_result[IDX_W-1:0];
                  req_ff     <= req_in;
               end else if (running_ff) begin
                  running_ff <= 1'b0;
                  done_ff    <= 1'b1;
                  rem_ff     <= alu_low_ff - quot_mod[IDX_W-1:0];
               end
            end
         end

         assign busy      = running_ff;
         assign idx_valid = done_ff;
         assign idx       = rem_ff;
         assign req_out   = req_ff;
      end
   endgenerate

endmodule
`default_nettype wire

@@ hdl/lsms_lane_unit.sv @@
// Lane selection for loads and read-modify-write merging for stores.
`default_nettype none
module lsms_lane_unit
   import lsms_pkg::*;
(
   input  wire req_type         req,
   input  wire logic [31:0]     word,
   input  wire rsp_type         held,
   output lane_result_type      result
);

   always_comb begin
      logic [7:0]  byte_in;
      logic [15:0] half_in;
      byte_in = req.reg_value[7:0];
      half_in = req.reg_value[15:0];

      result.wr_en     = 1'b0;
      result.wr_data   = word;
      result.dest_reg  = held.dest_reg_out;
      result.reg_value = held.reg_value_out;
      result.data      = held.data_out;

      case (req.opcode)
         OP_LB: begin
            result.dest_reg = req.dest_reg;
            case (req.byte_offset)
               2'd0:    result.data = (word & MASK_TOP_BYTE) >> 24;
               2'd1:    result.data = {24'd0, word[23:16]};
               2'd2:    result.data = {24'd0, word[15:8]};
               default: result.data = {24'd0, word[7:0]};
            endcase
         end
         OP_LH: begin
            result.dest_reg = req.dest_reg;
            // Lanes 2 and 3 are not halfword lanes; the data stays as it was.
            if (req.byte_offset == 2'd0) begin
               result.data = (word & MASK_UPPER_HALF) >> 16;
            end else if (req.byte_offset == 2'd1) begin
               result.data = word & MASK_LOWER_HALF;
            end
         end
         OP_LW: begin
            result.dest_reg = req.dest_reg;
            result.data     = word;
         end
         OP_SB: begin
            result.wr_en = 1'b1;
            case (req.byte_offset)
               2'd0:    result.wr_data = (word & MASK_LOW_THREE) | {byte_in, 24'd0};
               2'd1:    result.wr_data = {word[31:24], byte_in, word[15:0]};
               2'd2:    result.wr_data = {word[31:16], byte_in, word[7:0]};
               default: result.wr_data = {word[31:8], byte_in};
            endcase
         end
         OP_SH: begin
            if (req.byte_offset == 2'd0) begin
               result.wr_en   = 1'b1;
               result.wr_data = (word & MASK_LOWER_HALF) | {half_in, 16'd0};
            end else if (req.byte_offset == 2'd1) begin
               result.wr_en   = 1'b1;
               result.wr_data = (word & MASK_UPPER_HALF) | {16'd0, half_in};
            end
         end
         OP_SW: begin
            result.wr_en   = 1'b1;
            result.wr_data = req.reg_value;
         end
         default: begin
            result.dest_reg  = req.dest_reg;
            result.reg_value = req.reg_value;
            result.data      = req.alu_result;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/lsms_checker.sv @@
// Port-level checks for the load/store memory stage, bound to the top level.
`default_nettype none
module lsms_checker
   import lsms_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   logic is_store;
   logic is_load;

   assign is_store   = rsp_data.opcode_out inside {OP_SB, OP_SH, OP_SW};
   assign is_load    = rsp_data.opcode_out inside {OP_LB, OP_LH, OP_LW};

   // The clearing sweep keeps the stage busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("stage not busy after reset");

   // A store transaction leaves every held result field unchanged.
   a_store_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && is_store |->
         rsp_data.dest_reg_out == $past(rsp_data.dest_reg_out) &&
         rsp_data.reg_value_out == $past(rsp_data.reg_value_out) &&
         rsp_data.data_out == $past(rsp_data.data_out))
      else $error("store changed a held result field");

   // A load transaction does not touch the passed register value.
   a_load_holds_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && is_load |->
         rsp_data.reg_value_out == $past(rsp_data.reg_value_out))
      else $error("load changed reg_value_out");

   // Byte loads are zero-extended.
   a_byte_zero_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.opcode_out == OP_LB |-> rsp_data.data_out[31:8] == '0)
      else $error("byte load not zero-extended");

   // Between strobes the result ports keep their last transaction.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe && !$past(reset) |-> $stable(rsp_data))
      else $error("result changed without a strobe");

endmodule

bind load_store_memory_stage lsms_checker u_lsms_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
